// ===== design/fmra_pkg.sv =====
// Package for the field-masked register ALU: payload structs, operation and
// field codes, and the pipeline stage record. No dependencies.
package fmra_pkg;

    localparam int DataW   = 64;
    localparam int HalfW   = 32;
    localparam int DivSteps = 64;

    localparam logic [3:0] OP_COPY = 4'd0;
    localparam logic [3:0] OP_ADD  = 4'd1;
    localparam logic [3:0] OP_SUB  = 4'd2;
    localparam logic [3:0] OP_MUL  = 4'd3;
    localparam logic [3:0] OP_DIV  = 4'd4;
    localparam logic [3:0] OP_MOD  = 4'd5;
    localparam logic [3:0] OP_NOT  = 4'd6;
    localparam logic [3:0] OP_NEG  = 4'd7;
    localparam logic [3:0] OP_SHL  = 4'd8;
    localparam logic [3:0] OP_SHR  = 4'd9;
    localparam logic [3:0] OP_XOR  = 4'd10;

    localparam logic [3:0] FS_P  = 4'd0;
    localparam logic [3:0] FS_WP = 4'd1;
    localparam logic [3:0] FS_XS = 4'd2;
    localparam logic [3:0] FS_X  = 4'd3;
    localparam logic [3:0] FS_S  = 4'd4;
    localparam logic [3:0] FS_M  = 4'd5;
    localparam logic [3:0] FS_B  = 4'd6;
    localparam logic [3:0] FS_A  = 4'd15;

    typedef struct packed {
        logic [3:0]       op;
        logic [3:0]       field_select;
        logic [3:0]       pointer_nibble;
        logic [DataW-1:0] dest_value;
        logic [DataW-1:0] source_value;
    } t_in;

    typedef struct packed {
        logic [DataW-1:0] new_dest_value;
        logic             div_by_zero;
    } t_out;

    typedef struct packed {
        logic             valid;
        logic [3:0]       op;
        logic [DataW-1:0] dv;
        logic [DataW-1:0] fmask;
        logic [5:0]       sh;
        logic [DataW-1:0] a;
        logic [DataW-1:0] b;
        logic             dz;
        logic [DataW-1:0] res;
        logic [DataW-1:0] pp_ll;
        logic [HalfW-1:0] pp_lh;
        logic [HalfW-1:0] pp_hl;
        logic [DataW-1:0] rem;
        logic [DataW-1:0] quo;
    } t_stage;

endpackage

// ===== design/field_masked_register_alu.sv =====
// Top level of the field-masked register ALU: a 66-stage pipeline with a
// restoring divider, one quotient bit per stage. Depends on fmra_pkg.

// One instruction enters per cycle while the output is not stalled; the depth
// is set by the divider, which resolves one quotient bit in each
// of 64 stages, plus the field extract stage and the output register. All
// operations take the same path, so results leave in order. A stall on the
// output freezes the whole pipeline.
module field_masked_register_alu (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fmra_pkg::t_in     i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fmra_pkg::t_out    o_out_data
);

    localparam int NumSt = fmra_pkg::DivSteps + 1;

    fmra_pkg::t_stage r_st [NumSt];
    fmra_pkg::t_stage n_st [NumSt];
    logic             adv;

    assign adv        = !o_out_valid || i_out_ready;
    assign o_in_ready = adv;

    // Stage 0: locate the field and extract both operands.
    logic [3:0] start_nib;
    logic [4:0] len_nib;
    logic [fmra_pkg::DataW-1:0] lmask;
    logic [5:0] sh0;

    always_comb begin
        case (i_in_data.field_select)
            fmra_pkg::FS_P: begin
                start_nib = i_in_data.pointer_nibble; len_nib = 5'd1;
            end
            fmra_pkg::FS_WP: begin
                start_nib = 4'd0; len_nib = {1'b0, i_in_data.pointer_nibble} + 5'd1;
            end
            fmra_pkg::FS_XS: begin start_nib = 4'd2;  len_nib = 5'd1;  end
            fmra_pkg::FS_X:  begin start_nib = 4'd0;  len_nib = 5'd3;  end
            fmra_pkg::FS_S:  begin start_nib = 4'd15; len_nib = 5'd1;  end
            fmra_pkg::FS_M:  begin start_nib = 4'd3;  len_nib = 5'd12; end
            fmra_pkg::FS_B:  begin start_nib = 4'd0;  len_nib = 5'd2;  end
            fmra_pkg::FS_A:  begin start_nib = 4'd0;  len_nib = 5'd5;  end
            default:         begin start_nib = 4'd0;  len_nib = 5'd16; end
        endcase
        sh0 = {start_nib, 2'b00};
        if (len_nib[4]) begin
            lmask = '1;
        end else begin
            lmask = ({{(fmra_pkg::DataW-1){1'b0}}, 1'b1} << {len_nib[3:0], 2'b00})
                    - {{(fmra_pkg::DataW-1){1'b0}}, 1'b1};
        end
        n_st[0]       = r_st[0];
        n_st[0].valid = i_in_valid;
        n_st[0].op    = i_in_data.op;
        n_st[0].dv    = i_in_data.dest_value;
        n_st[0].fmask = lmask;
        n_st[0].sh    = sh0;
        n_st[0].a     = (i_in_data.dest_value >> sh0) & lmask;
        n_st[0].b     = (i_in_data.source_value >> sh0) & lmask;
        n_st[0].quo   = (i_in_data.dest_value >> sh0) & lmask;
        n_st[0].rem   = '0;
    end

    for (genvar k = 1; k < NumSt; k++) begin : g_st
        logic [fmra_pkg::DataW:0] trial;
        always_comb begin
            n_st[k] = r_st[k-1];
            if (k == 1) begin
                n_st[k].dz    = (r_st[k-1].b == '0);
                n_st[k].pp_ll = {32'd0, r_st[k-1].a[31:0]} * {32'd0, r_st[k-1].b[31:0]};
                n_st[k].pp_lh = r_st[k-1].a[31:0] * r_st[k-1].b[63:32];
                n_st[k].pp_hl = r_st[k-1].a[63:32] * r_st[k-1].b[31:0];
                case (r_st[k-1].op)
                    fmra_pkg::OP_COPY: n_st[k].res = r_st[k-1].b;
                    fmra_pkg::OP_ADD:  n_st[k].res = r_st[k-1].a + r_st[k-1].b;
                    fmra_pkg::OP_SUB:  n_st[k].res = r_st[k-1].a - r_st[k-1].b;
                    fmra_pkg::OP_NOT:  n_st[k].res = ~r_st[k-1].b;
                    fmra_pkg::OP_NEG:  n_st[k].res = '0 - r_st[k-1].b;
                    fmra_pkg::OP_SHL:  n_st[k].res = (r_st[k-1].b[63:6] != '0) ? '0
                                           : r_st[k-1].a << r_st[k-1].b[5:0];
                    fmra_pkg::OP_SHR:  n_st[k].res = (r_st[k-1].b[63:6] != '0) ? '0
                                           : r_st[k-1].a >> r_st[k-1].b[5:0];
                    fmra_pkg::OP_XOR:  n_st[k].res = r_st[k-1].a ^ r_st[k-1].b;
                    default:           n_st[k].res = '0;
                endcase
            end
            if (k == 2 && r_st[k-1].op == fmra_pkg::OP_MUL) begin
                n_st[k].res = r_st[k-1].pp_ll
                            + {r_st[k-1].pp_lh + r_st[k-1].pp_hl, 32'd0};
            end
            // One restoring division step on the shifting dividend.
            trial = {r_st[k-1].rem, r_st[k-1].quo[63]};
            if (trial >= {1'b0, r_st[k-1].b}) begin
                n_st[k].rem = 64'(trial - {1'b0, r_st[k-1].b});
                n_st[k].quo = {r_st[k-1].quo[62:0], 1'b1};
            end else begin
                n_st[k].rem = trial[63:0];
                n_st[k].quo = {r_st[k-1].quo[62:0], 1'b0};
            end
        end
    end

    for (genvar k = 0; k < NumSt; k++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[k].valid <= 1'b0;
            end else if (adv) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    // Output stage: pick the result and merge it into the destination field.
    fmra_pkg::t_stage ls;
    logic [fmra_pkg::DataW-1:0] fin, wmask;
    logic                       fin_dz, wr;
    fmra_pkg::t_out             n_out;

    always_comb begin
        ls     = r_st[NumSt-1];
        fin    = ls.res;
        fin_dz = 1'b0;
        wr     = 1'b1;
        case (ls.op)
            fmra_pkg::OP_DIV: begin
                fin = ls.dz ? '1 : ls.quo; fin_dz = ls.dz;
            end
            fmra_pkg::OP_MOD: begin
                fin = ls.dz ? ls.a : ls.rem; fin_dz = ls.dz;
            end
            fmra_pkg::OP_COPY, fmra_pkg::OP_ADD, fmra_pkg::OP_SUB, fmra_pkg::OP_MUL,
            fmra_pkg::OP_NOT, fmra_pkg::OP_NEG, fmra_pkg::OP_SHL, fmra_pkg::OP_SHR,
            fmra_pkg::OP_XOR: wr = 1'b1;
            default: wr = 1'b0;
        endcase
        wmask = ls.fmask << ls.sh;
        n_out.new_dest_value = wr ? ((ls.dv & ~wmask) | ((fin << ls.sh) & wmask)) : ls.dv;
        n_out.div_by_zero    = fin_dz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= ls.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_out_data <= n_out;
        end
    end

endmodule

// ===== sim/tb_field_masked_register_alu.sv =====
`timescale 1ns / 1ps
// Testbench for the field-masked register ALU: a directed table followed by
// random instructions, checked in order against a field-masked ALU predictor.
// Depends on fmra_pkg and field_masked_register_alu.
module tb_field_masked_register_alu;

    localparam int NumRandom  = 1250;
    localparam int CycleLimit = 400000;
    localparam int Latency    = 66;

    // Field and operation codes that only the stimulus needs.
    localparam logic [3:0] FS_W          = 4'd7;
    localparam logic [3:0] FS_USER       = 4'd12;
    localparam logic [3:0] OP_RSVD_FIRST = 4'd11;
    localparam logic [3:0] OP_RSVD_LAST  = 4'd15;

    typedef struct packed {
        fmra_pkg::t_in  instr;
        logic           check_fixed;
        fmra_pkg::t_out fixed_result;
    } t_row;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    fmra_pkg::t_in    i_in_data = '0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    fmra_pkg::t_out   o_out_data;

    fmra_pkg::t_out   pending_results[$];
    fmra_pkg::t_out   fixed_results[$];
    logic             fixed_flags[$];
    int     error_count = 0;
    int     result_count = 0;
    int     dz_count = 0;
    int     cycle_count = 0;
    t_row   directed_rows[$];

    field_masked_register_alu DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [63:0] nibble_mask(input int unsigned len);
        if (len >= 16) begin
            return '1;
        end
        return (64'd1 << (4 * len)) - 64'd1;
    endfunction

    function automatic fmra_pkg::t_out alu_result(input fmra_pkg::t_in instr);
        int unsigned start, len;
        logic [63:0] a, b, r, m;
        logic write, dz;
        fmra_pkg::t_out res;
        write = 1'b1;
        dz = 1'b0;
        r = '0;
        case (instr.field_select)
            fmra_pkg::FS_P:  begin start = 32'(instr.pointer_nibble); len = 1; end
            fmra_pkg::FS_WP: begin start = 0; len = 32'(instr.pointer_nibble) + 1; end
            fmra_pkg::FS_XS: begin start = 2; len = 1; end
            fmra_pkg::FS_X:  begin start = 0; len = 3; end
            fmra_pkg::FS_S:  begin start = 15; len = 1; end
            fmra_pkg::FS_M:  begin start = 3; len = 12; end
            fmra_pkg::FS_B:  begin start = 0; len = 2; end
            fmra_pkg::FS_A:  begin start = 0; len = 5; end
            default: begin start = 0; len = 16; end
        endcase
        a = (instr.dest_value >> (4 * start)) & nibble_mask(len);
        b = (instr.source_value >> (4 * start)) & nibble_mask(len);
        case (instr.op)
            fmra_pkg::OP_COPY: r = b;
            fmra_pkg::OP_ADD:  r = a + b;
            fmra_pkg::OP_SUB:  r = a - b;
            fmra_pkg::OP_MUL:  r = a * b;
            fmra_pkg::OP_DIV:  if (b == 0) begin r = '1; dz = 1'b1; end else r = a / b;
            fmra_pkg::OP_MOD:  if (b == 0) begin r = a; dz = 1'b1; end else r = a % b;
            fmra_pkg::OP_NOT:  r = ~b;
            fmra_pkg::OP_NEG:  r = 64'd0 - b;
            fmra_pkg::OP_SHL:  r = (b >= 64) ? 64'd0 : (a << b[5:0]);
            fmra_pkg::OP_SHR:  r = (b >= 64) ? 64'd0 : (a >> b[5:0]);
            fmra_pkg::OP_XOR:  r = a ^ b;
            default: write = 1'b0;
        endcase
        m = nibble_mask(len) << (4 * start);
        res.new_dest_value = write ?
            ((instr.dest_value & ~m) | ((r << (4 * start)) & m)) : instr.dest_value;
        res.div_by_zero = dz;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH %s at result %0d: got %h, want %h", what,
                 result_count, got, want);
        error_count++;
    endtask

    function automatic t_row make_row(input logic [3:0] op, input logic [3:0] fs,
                                      input logic [3:0] p, input logic [63:0] d,
                                      input logic [63:0] s, input logic chk,
                                      input logic [63:0] nd, input logic dz);
        t_row row;
        row.instr = '{op, fs, p, d, s};
        row.check_fixed = chk;
        row.fixed_result = '{nd, dz};
        return row;
    endfunction

    task automatic send_instr(input fmra_pkg::t_in instr, input logic chk,
                              input fmra_pkg::t_out fixed);
        i_in_valid <= 1'b1;
        i_in_data  <= instr;
        pending_results.push_back(alu_result(instr));
        fixed_flags.push_back(chk);
        fixed_results.push_back(fixed);
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    task automatic idle_sender(input int n);
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    function automatic logic [63:0] random_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return {60'd0, 4'($urandom)};
            3: return {56'd0, 8'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // Receiver: stalls on its own period-driven pattern with random jitter.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (cycle_count % 3000 < 600) i_out_ready <= 1'b1;
            else i_out_ready <= ($urandom_range(0, 3) != 0);
        end
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected transfer", o_out_data.new_dest_value, '0);
            end else begin
                fmra_pkg::t_out want;
                want = pending_results.pop_front();
                if (fixed_flags.pop_front()) begin
                    fmra_pkg::t_out typed;
                    typed = fixed_results.pop_front();
                    if (typed != want)
                        report_mismatch("table entry", typed.new_dest_value,
                                        want.new_dest_value);
                end else begin
                    void'(fixed_results.pop_front());
                end
                if (o_out_data.new_dest_value !== want.new_dest_value)
                    report_mismatch("new_dest_value", o_out_data.new_dest_value,
                                    want.new_dest_value);
                if (o_out_data.div_by_zero !== want.div_by_zero)
                    report_mismatch("div_by_zero", {63'd0, o_out_data.div_by_zero},
                                    {63'd0, want.div_by_zero});
                if (want.div_by_zero) dz_count <= dz_count + 1;
            end
            result_count <= result_count + 1;
        end
        if (cycle_count > CycleLimit) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        fmra_pkg::t_in instr;
        int burst;
        int drain;
        directed_rows.push_back(make_row(fmra_pkg::OP_COPY, FS_W, 4'd0, '0, '1,
                                         1'b1, '1, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_ADD, FS_W, 4'd0, '1, 64'd1,
                                         1'b1, '0, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_SUB, FS_W, 4'd0, '0, 64'd1,
                                         1'b1, '1, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_MUL, FS_W, 4'd0, '1, '1,
                                         1'b1, 64'd1, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_DIV, FS_W, 4'd0, 64'd5, '0,
                                         1'b1, '1, 1'b1));
        directed_rows.push_back(make_row(fmra_pkg::OP_MOD, FS_W, 4'd0, 64'd5, '0,
                                         1'b1, 64'd5, 1'b1));
        directed_rows.push_back(make_row(fmra_pkg::OP_DIV, fmra_pkg::FS_B, 4'd0, '1,
                                         64'hff00, 1'b1, '1, 1'b1));
        directed_rows.push_back(make_row(fmra_pkg::OP_NOT, FS_W, 4'd0, '0, '0,
                                         1'b1, '1, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_NEG, FS_W, 4'd0, '0, 64'd1,
                                         1'b1, '1, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_SHL, FS_W, 4'd0, '1, 64'd64,
                                         1'b1, '0, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_SHR, FS_W, 4'd0, '1, '1,
                                         1'b1, '0, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_SHR, FS_W, 4'd0, '1, 64'd63,
                                         1'b1, 64'd1, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_XOR, FS_W, 4'd0, '1, '1,
                                         1'b1, '0, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_COPY, fmra_pkg::FS_WP, 4'd15, '0,
                                         '1, 1'b1, '1, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_COPY, FS_USER, 4'd3, '0, '1,
                                         1'b1, '1, 1'b0));
        directed_rows.push_back(make_row(OP_RSVD_FIRST, FS_W, 4'd0, 64'h1234, '1,
                                         1'b1, 64'h1234, 1'b0));
        directed_rows.push_back(make_row(OP_RSVD_LAST, fmra_pkg::FS_A, 4'd9, '1, '0,
                                         1'b1, '1, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_COPY, fmra_pkg::FS_P, 4'd15, '0,
                                         '1, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_ADD, fmra_pkg::FS_XS, 4'd0, '1,
                                         '1, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_SUB, fmra_pkg::FS_X, 4'd0, '0,
                                         64'd1, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_NOT, fmra_pkg::FS_S, 4'd0, '0,
                                         '0, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_MUL, fmra_pkg::FS_M, 4'd0, '1,
                                         '1, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_SHL, fmra_pkg::FS_B, 4'd0, 64'h3,
                                         64'h4, 1'b0, '0, 1'b0));
        directed_rows.push_back(make_row(fmra_pkg::OP_MOD, fmra_pkg::FS_A, 4'd0, '1,
                                         64'h7, 1'b0, '0, 1'b0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_instr(directed_rows[k].instr, directed_rows[k].check_fixed,
                       directed_rows[k].fixed_result);
        i_in_valid <= 1'b0;
        // Hold off until the pipeline has drained before the random part.
        while (pending_results.size() != 0) @(posedge i_clk);

        for (int n = 0; n < NumRandom; ) begin
            burst = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                : $urandom_range(1, 12);
            for (int j = 0; j < burst && n < NumRandom; j++, n++) begin
                instr.op = ($urandom_range(0, 19) == 0)
                         ? 4'($urandom_range(OP_RSVD_FIRST, OP_RSVD_LAST))
                         : 4'($urandom_range(fmra_pkg::OP_COPY, fmra_pkg::OP_XOR));
                instr.field_select = 4'($urandom);
                instr.pointer_nibble = 4'($urandom);
                instr.dest_value = random_word();
                instr.source_value = random_word();
                if (instr.op inside {fmra_pkg::OP_SHL, fmra_pkg::OP_SHR}
                    && $urandom_range(0, 1))
                    instr.source_value = 64'($urandom_range(0, 70));
                send_instr(instr, 1'b0, '0);
            end
            idle_sender($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 20));
        end
        i_in_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge i_clk);
        drain = 0;
        while (drain < Latency * 2) begin
            @(posedge i_clk);
            drain++;
        end
        $display("Ran %0d directed and %0d random instructions over all ops and fields;",
                 directed_rows.size(), NumRandom);
        $display("%0d results checked, %0d with a zero divisor.", result_count, dz_count);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
